/* hdl/pfdc_pkg.sv */
// shared types and constants for the packet fifo with duplicate filter and count
// no dependencies
package pfdc_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int LIMIT_W      = 7;
  localparam int CNT_W        = 7;
  localparam int SRC_W        = 16;
  localparam int DST_W        = 16;
  localparam int TS_W         = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;
  localparam logic [CNT_W-1:0]   CNT_MAX   = 7'd127;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_ADD = 2'd0;
  localparam mode_t MODE_FWD = 2'd1;
  localparam mode_t MODE_CNT = 2'd2;

  // one stored packet, source in the low bits
  typedef struct packed {
    logic [TS_W-1:0]  ts;
    logic [DST_W-1:0] dst;
    logic [SRC_W-1:0] src;
  } pkt_t;

  localparam int PKT_W = $bits(pkt_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } st_t;

  // sequencer to compare unit
  typedef struct packed {
    logic clr;
    logic step;
  } match_ctl_t;

endpackage

/* hdl/pfdc_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module pfdc_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/pfdc_match.sv */
// shared compare unit: checks one stored packet per step against the key,
// accumulates the duplicate flag and the range count. uses pfdc_pkg
module pfdc_match
  import pfdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  match_ctl_t       ctl,
  input  pkt_t             entry,
  input  pkt_t             key,
  input  logic [TS_W-1:0]  t_lo,
  input  logic [TS_W-1:0]  t_hi,
  output logic             dup,
  output logic [CNT_W-1:0] cnt,
  output pkt_t             last_entry
);

  logic             dup_r, dup_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  pkt_t             last_r;
  logic             eq_all;
  logic             in_range;

  assign eq_all   = (entry == key);
  assign in_range = (entry.dst == key.dst) && (entry.ts >= t_lo) && (entry.ts <= t_hi);

  always_comb begin
    dup_nxt = dup_r;
    cnt_nxt = cnt_r;
    if (ctl.clr) begin
      dup_nxt = 1'b0;
      cnt_nxt = '0;
    end else if (ctl.step) begin
      dup_nxt = dup_r | eq_all;
      if (in_range && (cnt_r != CNT_MAX)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dup_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      dup_r <= dup_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // forward reads exactly one entry, keep it for the result
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      last_r <= entry;
    end
  end

  assign dup        = dup_r;
  assign cnt        = cnt_r;
  assign last_entry = last_r;

endmodule

/* hdl/packet_fifo_with_dedupe_and_count_unit.sv */
// top level of the packet fifo with duplicate filter and range count
// uses pfdc_pkg, pfdc_ram and pfdc_match
//
// Usage:
//   in_*  : one command word per handshake; in_tuser selects add, forward or
//           count, in_tdata carries the packet and the time bounds.
//   out_* : one result word per command; out_tuser is the ok flag, out_tdata
//           carries the forwarded packet and the match count.
//   cfg_* : writes memory_limit; write only while no command is in flight.
// Sequencing: an add or count walks the live entries, a forward at most the
//   oldest one and an unused mode none, through a single compare unit, one
//   stored entry a cycle from the entry memory read port. The sequencer goes
//   from idle through scan to its final state, where the command commits and
//   its result word is registered in the output register. One command is in
//   work at a time; in_tready is high only while the sequencer is idle.
// Reset: store empty, memory_limit 64, no result pending. Entry memory is not
//   cleared; only live entries are ever read.
// Stall: a finished result waits in the output register; the sequencer holds
//   its final state until the register is free, so nothing is lost.
module packet_fifo_with_dedupe_and_count_unit
  import pfdc_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  // in_tdata: source[15:0], destination[31:16], timestamp[63:32],
  //           start_time[95:64], end_time[127:96]
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [127:0]       in_tdata,
  // in_tuser: mode[1:0]
  input  logic [1:0]         in_tuser,
  // out_tdata: out_source[15:0], out_destination[31:16], out_timestamp[63:32],
  //            match_count[70:64], zero[71]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [71:0]        out_tdata,
  // out_tuser: ok[0]
  output logic               out_tuser,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int LW = (OW > LIMIT_W) ? OW : LIMIT_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

  st_t st_r, st_nxt;

  mode_t           mode_r;
  pkt_t            key_r;
  logic [TS_W-1:0] t_lo_r, t_hi_r;

  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [OW-1:0]      occ_r, occ_nxt;
  logic [LIMIT_W-1:0] lim_r;
  logic [OW-1:0]      n_r;
  logic [AW-1:0]      ptr_r;
  logic               rd_vld_r;

  logic               out_tvalid_r;
  logic [71:0]        out_tdata_r, out_tdata_nxt;
  logic               out_tuser_r, out_tuser_nxt;

  logic               in_acc;
  logic               issue;
  logic               fin_go;
  logic               ram_we;
  logic [OW-1:0]      scan_len;
  match_ctl_t         mctl;

  pkt_t               rd_entry;
  logic               dup;
  logic [CNT_W-1:0]   cnt;
  pkt_t               fwd_entry;

  logic [LW-1:0]      lim_ext;
  logic [LW-1:0]      eff_ext;
  logic [OW-1:0]      eff;
  logic [OW-1:0]      drop;
  logic [OW:0]        head_sum;

  assign in_acc = in_tvalid && in_tready;

  // effective limit: zero acts as one, clamp at capacity
  assign lim_ext = LW'(lim_r);
  always_comb begin
    if (lim_ext == '0) begin
      eff_ext = LW'(1);
    end else if (lim_ext > LW'(CAPACITY)) begin
      eff_ext = LW'(CAPACITY);
    end else begin
      eff_ext = lim_ext;
    end
  end
  assign eff = eff_ext[OW-1:0];

  always_comb begin
    case (mode_r)
      MODE_ADD: scan_len = occ_r;
      MODE_CNT: scan_len = occ_r;
      MODE_FWD: scan_len = (occ_r != '0) ? OW'(1) : '0;
      default:  scan_len = '0;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) st_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (n_r == scan_len) st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_tvalid_r || out_tready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    fin_go    = 1'b0;
    case (st_r)
      ST_IDLE: in_tready = 1'b1;
      ST_SCAN: issue = (n_r != scan_len);
      ST_FIN:  fin_go = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  assign mctl.clr  = in_acc;
  assign mctl.step = rd_vld_r;

  pfdc_ram #(
    .W     (PKT_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (key_r),
    .re    (issue),
    .raddr (ptr_r),
    .rdata (rd_entry)
  );

  pfdc_match u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mctl),
    .entry      (rd_entry),
    .key        (key_r),
    .t_lo       (t_lo_r),
    .t_hi       (t_hi_r),
    .dup        (dup),
    .cnt        (cnt),
    .last_entry (fwd_entry)
  );

  // eviction: drop enough oldest entries to leave room for one under the limit
  assign drop     = occ_r - eff + OW'(1);
  assign head_sum = {1'b0, OW'(head_r)} + {1'b0, drop};

  // commit of the command in the final state
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    ram_we        = 1'b0;
    out_tdata_nxt = '0;
    out_tuser_nxt = 1'b0;
    case (mode_r)
      MODE_ADD: begin
        if (!dup) begin
          ram_we        = fin_go;
          out_tuser_nxt = 1'b1;
          tail_nxt      = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
          if (occ_r >= eff) begin
            if (head_sum >= (OW + 1)'(CAPACITY)) begin
              head_nxt = AW'(head_sum - (OW + 1)'(CAPACITY));
            end else begin
              head_nxt = AW'(head_sum);
            end
            occ_nxt = eff;
          end else begin
            occ_nxt = occ_r + 1'b1;
          end
        end
      end
      MODE_FWD: begin
        if (occ_r != '0) begin
          out_tuser_nxt       = 1'b1;
          out_tdata_nxt[63:0] = fwd_entry;
          head_nxt            = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
          occ_nxt             = occ_r - 1'b1;
        end
      end
      MODE_CNT: begin
        out_tdata_nxt[70:64] = cnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      occ_r        <= '0;
      lim_r        <= LIMIT_RST;
      n_r          <= '0;
      ptr_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      rd_vld_r <= issue;
      if (cfg_valid) begin
        lim_r <= cfg_data;
      end
      if (in_acc) begin
        n_r   <= '0;
        ptr_r <= head_r;
      end else if (issue) begin
        n_r   <= n_r + 1'b1;
        ptr_r <= (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;
      end
      if (fin_go) begin
        head_r       <= head_nxt;
        tail_r       <= tail_nxt;
        occ_r        <= occ_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r     <= in_tuser;
      key_r.src  <= in_tdata[15:0];
      key_r.dst  <= in_tdata[31:16];
      key_r.ts   <= in_tdata[63:32];
      t_lo_r     <= in_tdata[95:64];
      t_hi_r     <= in_tdata[127:96];
    end
    if (fin_go) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
